// File: hdl/fdsd_pkg.sv
package fdsd_pkg;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_NUMBER = 2'd1,
    REQ_ERROR  = 2'd2
  } req_kind_t;

  localparam int unsigned REM_W     = 14;
  localparam int unsigned QUOT_W    = 19;
  localparam int unsigned DIV_SHIFT = 45;
  localparam int unsigned DIGITS    = 4;
  localparam int unsigned STEP_W    = $clog2(DIGITS);

  localparam logic [31:0] DIV_MAGIC   = 32'hD1B7_1759;
  localparam logic [REM_W-1:0] RADIX  = 14'd10000;
  localparam logic [7:0] CMD_CONTROL  = 8'h48;
  localparam logic [7:0] CMD_DIGIT0   = 8'h68;
  localparam logic [7:0] PATTERN_E    = 8'h79;
  localparam logic [7:0] CTRL_RESET   = 8'h31;

  typedef struct packed {
    req_kind_t        kind;
    logic [REM_W-1:0] rem;
  } entry_t;

  function automatic logic [3:0] lead_digit(input logic [REM_W-1:0] rem);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= REM_W'(k * 1000)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [REM_W-1:0] thousands(input logic [3:0] d);
    logic [REM_W-1:0] t;
    unique case (d)
      4'd0:    t = 14'd0;
      4'd1:    t = 14'd1000;
      4'd2:    t = 14'd2000;
      4'd3:    t = 14'd3000;
      4'd4:    t = 14'd4000;
      4'd5:    t = 14'd5000;
      4'd6:    t = 14'd6000;
      4'd7:    t = 14'd7000;
      4'd8:    t = 14'd8000;
      4'd9:    t = 14'd9000;
      default: t = 14'd0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/fdsd_front.sv
module fdsd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_req_type,
  input  logic [31:0]          in_value,
  input  logic                 q_full,
  output logic                 push,
  output fdsd_pkg::entry_t     push_entry
);

  logic                              valid_r, valid_nxt;
  fdsd_pkg::req_kind_t               kind_r;
  logic [fdsd_pkg::QUOT_W-1:0]       quot_r;
  logic [fdsd_pkg::REM_W-1:0]        vlo_r;
  logic                              accept;
  logic                              kind_ok;
  logic [63:0]                       recip_prod;
  logic [32:0]                       back_prod;

  assign busy   = valid_r & q_full;
  assign accept = start & ~busy;
  assign push   = valid_r & ~q_full;

  assign kind_ok = (in_req_type == fdsd_pkg::REQ_INIT) ||
                   (in_req_type == fdsd_pkg::REQ_NUMBER) ||
                   (in_req_type == fdsd_pkg::REQ_ERROR);

  assign recip_prod = {32'b0, in_value} * {32'b0, fdsd_pkg::DIV_MAGIC};
  assign back_prod  = {14'b0, quot_r} * {19'b0, fdsd_pkg::RADIX};

  assign push_entry.kind = kind_r;
  assign push_entry.rem  = vlo_r - back_prod[fdsd_pkg::REM_W-1:0];

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = kind_ok;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= fdsd_pkg::req_kind_t'(in_req_type);
      quot_r <= recip_prod[63:fdsd_pkg::DIV_SHIFT];
      vlo_r  <= in_value[fdsd_pkg::REM_W-1:0];
    end
  end

  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> valid_r)
    else $error("stalled request was lost");

endmodule

// File: hdl/fdsd_queue.sv
module fdsd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fdsd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output fdsd_pkg::entry_t head
);

  fdsd_pkg::entry_t mem [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt  = count_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: hdl/fdsd_back.sv
module fdsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       display_control,
  input  logic             q_empty,
  input  fdsd_pkg::entry_t head,
  output logic             pop,
  output logic             out_strobe,
  output logic [7:0]       out_command_byte,
  output logic [7:0]       out_data_byte,
  output logic             out_last
);

  logic                              active_r, active_nxt;
  logic [fdsd_pkg::STEP_W-1:0]       step_r, step_nxt;
  fdsd_pkg::req_kind_t               kind_r, kind_nxt;
  logic [fdsd_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic                              strobe_r;
  logic [7:0]                        cmd_r, cmd_nxt;
  logic [7:0]                        data_r, data_nxt;
  logic                              last_r, last_nxt;
  logic                              finishing;
  logic [3:0]                        digit;
  logic [fdsd_pkg::REM_W-1:0]        rem_low;

  assign digit   = fdsd_pkg::lead_digit(rem_r);
  assign rem_low = rem_r - fdsd_pkg::thousands(digit);

  assign finishing = active_r &&
                     ((kind_r == fdsd_pkg::REQ_INIT) ||
                      (step_r == fdsd_pkg::STEP_W'(fdsd_pkg::DIGITS - 1)));
  assign pop = !q_empty && (!active_r || finishing);

  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    kind_nxt   = kind_r;
    rem_nxt    = rem_r;
    if (pop) begin
      active_nxt = 1'b1;
      step_nxt   = '0;
      kind_nxt   = head.kind;
      rem_nxt    = head.rem;
    end else if (active_r) begin
      active_nxt = !finishing;
      step_nxt   = step_r + 1'b1;
      rem_nxt    = (rem_low << 3) + (rem_low << 1);
    end
  end

  always_comb begin
    cmd_nxt  = fdsd_pkg::CMD_DIGIT0 + {5'b0, step_r, 1'b0};
    data_nxt = fdsd_pkg::PATTERN_E;
    last_nxt = (step_r == fdsd_pkg::STEP_W'(fdsd_pkg::DIGITS - 1));
    unique case (kind_r)
      fdsd_pkg::REQ_INIT: begin
        cmd_nxt  = fdsd_pkg::CMD_CONTROL;
        data_nxt = display_control;
        last_nxt = 1'b1;
      end
      fdsd_pkg::REQ_NUMBER: begin
        data_nxt = fdsd_pkg::seg_pattern(digit);
      end
      fdsd_pkg::REQ_ERROR: begin
        data_nxt = fdsd_pkg::PATTERN_E;
      end
      default: begin
        data_nxt = fdsd_pkg::PATTERN_E;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    kind_r <= kind_nxt;
    rem_r  <= rem_nxt;
    cmd_r  <= cmd_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_command_byte = cmd_r;
  assign out_data_byte    = data_r;
  assign out_last         = last_r;

  a_pairs_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !last_r |=> strobe_r)
    else $error("gap inside a request's pairs");

  a_init_single: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && step_r != '0 |-> kind_r != fdsd_pkg::REQ_INIT)
    else $error("init request ran past one pair");

endmodule

// File: hdl/four_digit_segment_display_formatter.sv
// Each request is held in the front register, then the queue, then the output stage registers.
// A number or error request gives 4 pairs on consecutive cycles, an init request 1 pair.
// Throughput: one pair per cycle while active; the next request is popped at the last pair.
// A two-entry queue between the divider front end and the output stage absorbs bursts.
// Synchronous reset clears the pipeline and queue and sets the control byte to 0x31.
// The receiver cannot stall: busy is high only while the front register and queue are full.
module four_digit_segment_display_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic [7:0]  out_command_byte,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]       display_control_r;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  fdsd_pkg::entry_t push_entry;
  fdsd_pkg::entry_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_control_r <= fdsd_pkg::CTRL_RESET;
    end else if (cfg_we) begin
      display_control_r <= cfg_wdata;
    end
  end

  fdsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  fdsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  fdsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .display_control  (display_control_r),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_command_byte (out_command_byte),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNDEFINED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 10;

  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] data;
    logic       last;
  } display_pair_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_value;
  logic        out_strobe;
  logic [7:0]  out_command_byte;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  display_pair_t expected_pairs [$];
  logic [7:0]    control_shadow;
  int unsigned   sender_idle_pct;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  four_digit_segment_display_formatter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_command_byte (out_command_byte),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("four_digit_segment_display_formatter regression: fail");
      $finish;
    end
  end

  function automatic void predict_display_pairs(input logic [1:0] req, input logic [31:0] value);
    int unsigned  rest;
    int unsigned  digit [4];
    display_pair_t pair;
    rest = value % 10000;
    digit[0] = rest / 1000;
    digit[1] = (rest / 100) % 10;
    digit[2] = (rest / 10) % 10;
    digit[3] = rest % 10;
    case (req)
      fdsd_pkg::REQ_INIT: begin
        pair.command = fdsd_pkg::CMD_CONTROL;
        pair.data = control_shadow;
        pair.last = 1'b1;
        expected_pairs.push_back(pair);
      end
      fdsd_pkg::REQ_NUMBER, fdsd_pkg::REQ_ERROR: begin
        for (int i = 0; i < 4; i++) begin
          pair.command = fdsd_pkg::CMD_DIGIT0 + 8'(2 * i);
          pair.data = (req == fdsd_pkg::REQ_NUMBER) ? DIGIT_SEGMENTS[digit[i]] :
                      fdsd_pkg::PATTERN_E;
          pair.last = (i == 3);
          expected_pairs.push_back(pair);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    display_pair_t want;
    if (rst_n && out_strobe) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected pair: command %h data %h last %b",
               out_command_byte, out_data_byte, out_last);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_command_byte !== want.command) begin
          $error("command_byte: expected %h, got %h", want.command, out_command_byte);
          fail_count++;
        end
        if (out_data_byte !== want.data) begin
          $error("data_byte: expected %h, got %h", want.data, out_data_byte);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [31:0] value);
    logic ready;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_value <= value;
    forever begin
      ready = !busy;
      @(posedge clk);
      if (ready) begin
        break;
      end
      @(negedge clk);
    end
    predict_display_pairs(req, value);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pairs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_control(input logic [7:0] control);
    drain_and_settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= control;
    @(posedge clk);
    control_shadow = control;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 8'($urandom);
  endtask

  task automatic test_control_after_reset();
    send_request(fdsd_pkg::REQ_INIT, 32'd0);
    send_request(fdsd_pkg::REQ_INIT, 32'hFFFF_FFFF);
  endtask

  task automatic test_number_extremes();
    send_request(fdsd_pkg::REQ_NUMBER, 32'd0);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd9999);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd10000);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd123);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd4567);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd8901);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd1000);
    send_request(fdsd_pkg::REQ_NUMBER, 32'hFFFF_FFFF);
    send_request(fdsd_pkg::REQ_NUMBER, 32'h8000_0000);
    send_request(fdsd_pkg::REQ_NUMBER, 32'h5555_5555);
    send_request(fdsd_pkg::REQ_NUMBER, 32'hAAAA_AAAA);
  endtask

  task automatic test_error_pattern();
    send_request(fdsd_pkg::REQ_ERROR, 32'd0);
    send_request(fdsd_pkg::REQ_ERROR, 32'hFFFF_FFFF);
  endtask

  task automatic test_undefined_request();
    send_request(REQ_UNDEFINED, 32'd0);
    send_request(REQ_UNDEFINED, 32'hFFFF_FFFF);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd42);
  endtask

  task automatic test_control_register();
    write_control(8'h00);
    send_request(fdsd_pkg::REQ_INIT, 32'd7);
    write_control(8'hFF);
    send_request(fdsd_pkg::REQ_INIT, 32'd7);
    write_control(8'hA5);
    send_request(fdsd_pkg::REQ_INIT, 32'd0);
    send_request(fdsd_pkg::REQ_NUMBER, 32'd2468);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [31:0] value;
    sender_idle_pct = idle_pct;
    write_control(8'($urandom));
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(3))
        0: value = $urandom;
        1: value = $urandom_range(9999);
        2: value = $urandom_range(429496) * 10000 + $urandom_range(2) * 4999;
        default: value = 32'hFFFF_FFFF - $urandom_range(20000);
      endcase
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_request(fdsd_pkg::REQ_NUMBER, value);
        sent++;
      end else if (pick < 75) begin
        send_request(fdsd_pkg::REQ_INIT, value);
        sent++;
      end else if (pick < 90) begin
        send_request(fdsd_pkg::REQ_ERROR, value);
        sent++;
      end else begin
        send_request(REQ_UNDEFINED, value);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = fdsd_pkg::REQ_INIT;
    in_value = 32'd0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    control_shadow = fdsd_pkg::CTRL_RESET;
    sender_idle_pct = 26;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_control_after_reset();
    test_number_extremes();
    test_error_pattern();
    test_undefined_request();
    test_control_register();
    test_random_traffic(26, 85);
    test_random_traffic(53, 85);
    test_random_traffic(0, 85);

    drain_and_settle();
    if (fail_count == 0) begin
      $display("four_digit_segment_display_formatter regression: pass");
    end else begin
      $display("four_digit_segment_display_formatter regression: fail");
    end
    $finish;
  end

endmodule
